>>> design/lit_pkg.sv
// lit_pkg: shared types, sizes and character codes for the lexer with identifier table
// used by lit_cell and lexer_identifier_table
package lit_pkg;

  localparam int MAX_LEN = 16;
  localparam int ENTRIES = 16;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int WIDX_W = $clog2(MAX_LEN);
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int VAL_W  = 54;
  localparam int KIND_W = 3;

  localparam logic [VAL_W-1:0] NUM_LIMIT  = 54'd9999999999999999;
  // largest accumulator that may still take one more digit
  localparam logic [VAL_W-1:0] NUM_THRESH = 54'd999999999999999;

  localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INTEGER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OP      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  localparam logic [7:0] KW_TEXT [4][6] = '{
    '{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74},  // struct
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},  // return
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00}   // char
  };
  localparam logic [LEN_W-1:0] KW_LEN [4] = '{
    LEN_W'(6), LEN_W'(3), LEN_W'(6), LEN_W'(4)
  };

  typedef logic [MAX_LEN-1:0][7:0] word_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_STRING = 2'd2,
    MODE_NUMBER = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [IDX_W-1:0] idx;
  } link_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_EQ;
  endfunction

  // keyword match, returns {hit, number}
  function automatic logic [2:0] kw_match(input word_t w, input logic [LEN_W-1:0] len);
    logic [2:0] r;
    logic       eq;
    r = 3'd0;
    for (int k = 3; k >= 0; k--) begin
      eq = (len == KW_LEN[k]);
      for (int i = 0; i < 6; i++) begin
        if (LEN_W'(i) < KW_LEN[k] && w[i] != KW_TEXT[k][i]) eq = 1'b0;
      end
      if (eq) r = {1'b1, 2'(k)};
    end
    return r;
  endfunction

endpackage

>>> design/lexer_identifier_table.sv
// lexer_identifier_table: scanner, output queue and a chain of lit_cell table entries
// depends on lit_pkg and lit_cell
//
//   channel   dir  payload
//   s_*       in   tdata: character[7:0]; tuser: end_of_text
//   m_*       out  tdata: token_kind[2:0], token_value[56:3]; tlast: last_of_run
//
// each byte queues at most two results, a token and an operator
// a word that is not a keyword waits in ST_SEARCH while the search token walks the cell chain
// a new byte is taken only once the result queue is empty
// synchronous reset clears scan state and the table count; names need no clearing
module lexer_identifier_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // character[7:0]
  input  logic        s_tuser,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // token_kind[2:0], token_value[56:3], zero fill
  output logic        m_tlast
);
  import lit_pkg::*;

  state_t           state, state_next;
  mode_t            mode, mode_next;
  word_t            word, word_next;
  logic [LEN_W-1:0] word_len, word_len_next;
  logic [VAL_W-1:0] acc, acc_next;
  logic [7:0]       prev, prev_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       pend_c, pend_c_next;
  logic             pend_eot, pend_eot_next;
  logic             q0v, q1v, q0v_next, q1v_next;
  logic [KIND_W-1:0] q0k, q1k, q0k_next, q1k_next;
  logic [VAL_W-1:0] q0d, q1d, q0d_next, q1d_next;

  link_t            link [ENTRIES+1];
  logic             start, store;

  logic             tok_v, op_v, fin, do_post, post_eot;
  logic [KIND_W-1:0] tok_k;
  logic [VAL_W-1:0] tok_d, digit;
  logic [7:0]       c, post_c;
  logic [2:0]       kw;

  assign c        = s_tdata;
  assign s_tready = (state == ST_IDLE) && !q0v;
  assign m_tvalid = q0v;
  assign m_tdata  = {7'd0, q0d, q0k};
  assign m_tlast  = !q1v;

  assign link[0] = '{vld: start, found: 1'b0, idx: '0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lit_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .count    (count),
      .word     (word),
      .word_len (word_len),
      .wr_en    (store && count == CNT_W'(g)),
      .link_in  (link[g]),
      .link_out (link[g+1])
    );
  end

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    word_next     = word;
    word_len_next = word_len;
    acc_next      = acc;
    prev_next     = prev;
    count_next    = count;
    pend_c_next   = pend_c;
    pend_eot_next = pend_eot;
    q0v_next = q0v; q1v_next = q1v;
    q0k_next = q0k; q1k_next = q1k;
    q0d_next = q0d; q1d_next = q1d;
    start    = 1'b0;
    store    = 1'b0;
    tok_v    = 1'b0;
    tok_k    = KIND_IDENT;
    tok_d    = '0;
    op_v     = 1'b0;
    fin      = 1'b0;
    do_post  = 1'b0;
    post_eot = 1'b0;
    post_c   = c;
    kw       = kw_match(word, word_len);
    digit    = VAL_W'(c - 8'h30);

    if (m_tvalid && m_tready) begin
      q0v_next = q1v; q0k_next = q1k; q0d_next = q1d;
      q1v_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          prev_next = s_tuser ? 8'h00 : c;
          if (s_tuser) begin
            do_post  = 1'b1;
            post_eot = 1'b1;
            if (mode == MODE_WORD) fin = 1'b1;
            else if (mode == MODE_NUMBER) begin
              tok_v = 1'b1; tok_k = KIND_INTEGER; tok_d = acc;
            end
          end else begin
            case (mode)
              MODE_WORD: begin
                if (is_alpha(c) || is_digit(c)) begin
                  if (word_len < LEN_W'(MAX_LEN)) begin
                    word_next[word_len[WIDX_W-1:0]] = c;
                    word_len_next = word_len + LEN_W'(1);
                  end
                end else begin
                  fin     = 1'b1;
                  do_post = 1'b1;
                end
              end
              MODE_STRING: begin
                if (c == CH_QUOTE && prev != CH_BSL) mode_next = MODE_IDLE;
              end
              MODE_NUMBER: begin
                if (is_digit(c)) begin
                  acc_next = (acc > NUM_THRESH) ? NUM_LIMIT
                                                : (acc << 3) + (acc << 1) + digit;
                end else begin
                  tok_v = 1'b1; tok_k = KIND_INTEGER; tok_d = acc;
                  do_post = 1'b1;
                end
              end
              default: do_post = 1'b1;
            endcase
          end
          if (fin) begin
            if (kw[2]) begin
              tok_v = 1'b1; tok_k = KIND_KEYWORD; tok_d = VAL_W'(kw[1:0]);
            end else begin
              // defer the ending byte until the table search returns
              start         = 1'b1;
              do_post       = 1'b0;
              pend_c_next   = c;
              pend_eot_next = s_tuser;
              state_next    = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (link[ENTRIES].vld) begin
          tok_v = 1'b1;
          if (link[ENTRIES].found) begin
            tok_k = KIND_IDENT; tok_d = VAL_W'(link[ENTRIES].idx);
          end else if (count >= CNT_W'(ENTRIES)) begin
            tok_k = KIND_FULL; tok_d = '0;
          end else begin
            tok_k = KIND_IDENT; tok_d = VAL_W'(count);
            store = 1'b1;
            count_next = count + CNT_W'(1);
          end
          do_post    = 1'b1;
          post_eot   = pend_eot;
          post_c     = pend_c;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (do_post) begin
      mode_next     = MODE_IDLE;
      word_len_next = '0;
      acc_next      = '0;
      if (post_eot) begin
        count_next = '0;
      end else if (post_c == CH_QUOTE) begin
        mode_next = MODE_STRING;
      end else if (is_alpha(post_c)) begin
        word_next[0]  = post_c;
        word_len_next = LEN_W'(1);
        mode_next     = MODE_WORD;
      end else if (is_digit(post_c)) begin
        acc_next  = VAL_W'(post_c - 8'h30);
        mode_next = MODE_NUMBER;
      end else if (is_op(post_c)) begin
        op_v = 1'b1;
      end
    end

    // results only arrive while the queue is empty
    if (tok_v) begin
      q0v_next = 1'b1; q0k_next = tok_k; q0d_next = tok_d;
      q1v_next = op_v; q1k_next = KIND_OP; q1d_next = VAL_W'(post_c);
    end else if (op_v) begin
      q0v_next = 1'b1; q0k_next = KIND_OP; q0d_next = VAL_W'(post_c);
      q1v_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= MODE_IDLE;
      word_len <= '0;
      acc      <= '0;
      prev     <= '0;
      count    <= '0;
      q0v      <= 1'b0;
      q1v      <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      word_len <= word_len_next;
      acc      <= acc_next;
      prev     <= prev_next;
      count    <= count_next;
      q0v      <= q0v_next;
      q1v      <= q1v_next;
    end
    word     <= word_next;
    pend_c   <= pend_c_next;
    pend_eot <= pend_eot_next;
    q0k      <= q0k_next;
    q0d      <= q0d_next;
    q1k      <= q1k_next;
    q1d      <= q1d_next;
  end

`ifndef ASSERT_OFF
  a_chain_in_search: assert property (@(posedge clk) disable iff (rst)
    link[ENTRIES].vld |-> state == ST_SEARCH)
    else $error("search token outside search");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    q1v |-> q0v)
    else $error("second result without first");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("table count overflow");
`endif

endmodule

>>> design/lit_cell.sv
// lit_cell: one identifier table entry with its compare logic and a stage of the search chain
// depends on lit_pkg
module lit_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lit_pkg::IDX_W-1:0] cell_idx,
  input  logic [lit_pkg::CNT_W-1:0] count,
  input  lit_pkg::word_t            word,
  input  logic [lit_pkg::LEN_W-1:0] word_len,
  input  logic                      wr_en,
  input  lit_pkg::link_t            link_in,
  output lit_pkg::link_t            link_out
);
  import lit_pkg::*;

  word_t            name;
  logic [LEN_W-1:0] name_len;
  logic             match;

  always_comb begin
    match = (CNT_W'(cell_idx) < count) && (name_len == word_len);
    for (int i = 0; i < MAX_LEN; i++) begin
      if (LEN_W'(i) < word_len && name[i] != word[i]) match = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      name     <= word;
      name_len <= word_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.vld <= 1'b0;
    end else begin
      link_out.vld <= link_in.vld;
    end
    link_out.found <= link_in.found | match;
    link_out.idx   <= link_in.found ? link_in.idx : cell_idx;
  end

endmodule

>>> test/lexer_token_checker.sv
`timescale 1ns / 100ps
// lexer_token_checker: watches both stream channels of the lexer, predicts the tokens
// each accepted byte yields and compares them with what the block emits; uses lit_pkg
module lexer_token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          tokens_seen
);
  import lit_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic              last;
  } token_t;

  token_t token_q[$];

  mode_t            mode;
  logic [7:0]       word_buf [MAX_LEN];
  int               word_len;
  logic [VAL_W-1:0] num_acc;
  logic [7:0]       prev_ch;
  logic [7:0]       names [ENTRIES][MAX_LEN];
  int               name_len [ENTRIES];
  int               n_names;
  token_t           step_toks [$];

  assign pending = token_q.size();

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit operator_ch(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_EQ;
  endfunction

  task automatic emit(logic [KIND_W-1:0] k, logic [VAL_W-1:0] v);
    step_toks.push_back('{k, v, 1'b0});
  endtask

  task automatic close_word();
    string kw [4];
    bit    hit;
    kw = '{"struct", "int", "return", "char"};
    for (int k = 0; k < 4; k++) begin
      hit = (word_len == kw[k].len());
      for (int i = 0; hit && i < word_len; i++)
        if (word_buf[i] != kw[k][i]) hit = 0;
      if (hit) begin
        emit(KIND_KEYWORD, VAL_W'(k));
        return;
      end
    end
    for (int e = 0; e < n_names; e++) begin
      hit = (name_len[e] == word_len);
      for (int i = 0; hit && i < word_len; i++)
        if (names[e][i] != word_buf[i]) hit = 0;
      if (hit) begin
        emit(KIND_IDENT, VAL_W'(e));
        return;
      end
    end
    if (n_names >= ENTRIES) begin
      emit(KIND_FULL, '0);
      return;
    end
    for (int i = 0; i < word_len; i++) names[n_names][i] = word_buf[i];
    name_len[n_names] = word_len;
    emit(KIND_IDENT, VAL_W'(n_names));
    n_names++;
  endtask

  task automatic start_token(logic [7:0] c);
    mode = MODE_IDLE;
    if (c == CH_QUOTE) mode = MODE_STRING;
    else if (letter(c)) begin
      word_buf[0] = c;
      word_len = 1;
      mode = MODE_WORD;
    end else if (digit(c)) begin
      num_acc = VAL_W'(c - "0");
      mode = MODE_NUMBER;
    end else if (operator_ch(c)) emit(KIND_OP, VAL_W'(c));
  endtask

  task automatic predict_byte(logic [7:0] c, logic eot);
    logic [VAL_W-1:0] d;
    step_toks.delete();
    if (eot) begin
      if (mode == MODE_WORD) close_word();
      else if (mode == MODE_NUMBER) emit(KIND_INTEGER, num_acc);
      mode = MODE_IDLE;
      word_len = 0;
      num_acc = '0;
      prev_ch = '0;
      n_names = 0;
    end else begin
      case (mode)
        MODE_WORD: begin
          if (letter(c) || digit(c)) begin
            if (word_len < MAX_LEN) begin
              word_buf[word_len] = c;
              word_len++;
            end
          end else begin
            close_word();
            word_len = 0;
            start_token(c);
          end
        end
        MODE_STRING: if (c == CH_QUOTE && prev_ch != CH_BSL) mode = MODE_IDLE;
        MODE_NUMBER: begin
          if (digit(c)) begin
            d = VAL_W'(c - "0");
            if (num_acc > (NUM_LIMIT - d) / 10) num_acc = NUM_LIMIT;
            else num_acc = num_acc * 10 + d;
          end else begin
            emit(KIND_INTEGER, num_acc);
            num_acc = '0;
            start_token(c);
          end
        end
        default: start_token(c);
      endcase
      prev_ch = c;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  always @(posedge clk) begin
    token_t got, want;
    if (rst) begin
      mode = MODE_IDLE;
      word_len = 0;
      num_acc = '0;
      prev_ch = '0;
      n_names = 0;
      errors = 0;
      tokens_seen = 0;
      token_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[56:3], m_tlast};
        tokens_seen++;
        if (token_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected token kind %0d value %0d", got.kind, got.value);
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("token mismatch: expected kind %0d value %0d last %0b, got %0d %0d %0b",
                       want.kind, want.value, want.last, got.kind, got.value, got.last);
          end
        end
      end
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tuser);
    end
  end

endmodule

>>> test/tb_lexer_identifier_table.sv
`timescale 1ns / 100ps
// tb_lexer_identifier_table: drives source text into the lexer with random gaps on both
// sides and gives the verdict; depends on lit_pkg, the lexer and lexer_token_checker
module tb_lexer_identifier_table;
  import lit_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  int          errors, pending, tokens_seen;
  int          idle_cycles;
  int          bytes_sent;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lexer_identifier_table u_dut (.*);

  lexer_token_checker u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // sink stall pattern, with calm stretches of constant ready
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) m_tready <= 0;
    else if ((bytes_sent / 200) % 3 == 1) m_tready <= 1;
    else if (r < 8) m_tready <= 0;
    else if (r < 70) m_tready <= 1;
    else m_tready <= (r % 2);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog: no transfer for too long");
      $display("== FAIL ==");
      $finish;
    end
  end

  // tvalid stays high on return so that the next byte can follow at once
  task automatic send(logic [7:0] c, logic eot, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= c;
    s_tuser  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit gaps);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0, gaps);
  endtask

  function automatic string rand_word();
    string s, pool;
    int n;
    pool = "abcxyzABZ_019";
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
    s = "";
    s = {s, string'(pool[$urandom_range(0, 8)])};
    for (int i = 1; i < n; i++) s = {s, string'(pool[$urandom_range(0, 12)])};
    return s;
  endfunction

  function automatic string rand_piece();
    string kw [4];
    string ops, s;
    int r;
    kw = '{"struct", "int", "return", "char"};
    ops = "+-*/=";
    r = $urandom_range(0, 99);
    if (r < 15) return kw[$urandom_range(0, 3)];
    if (r < 45) return rand_word();
    if (r < 60) begin
      s = "";
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 4))
        s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      return s;
    end
    if (r < 72) return string'(ops[$urandom_range(0, 4)]);
    if (r < 80) return ($urandom_range(0, 1)) ? "\"a+b\\\"=c\"" : "\"x-y\"";
    if (r < 92) return " ";
    return string'(8'($urandom_range(1, 255)));
  endfunction

  initial begin
    string s;
    bytes_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: keywords, names, ending character, operators, strings, long word
    send_text("struct int return char foo foo9=12+_x*", 0);
    send_text("3/4-\"a=b\\\"+\"z ", 1);
    send_text("abcdefghijklmnopqrstu abcdefghijklmnopq", 1);
    send(8'hff, 1'b0, 1);
    send(8'h00, 1'b0, 1);
    send_text("99999999999999999999", 0);
    send(8'h00, 1'b1, 1);
    // fill the table past its size
    for (int i = 0; i < ENTRIES + 2; i++) send_text({"n", string'(8'("a" + i)), " "}, 1);
    send_text("q7", 0);
    send(8'h00, 1'b1, 0);
    send_text("\"open", 0);
    send(8'h00, 1'b1, 0);
    s_tvalid <= 0;
    // hold off until every token has drained
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    while (bytes_sent < 1300) begin
      if ($urandom_range(0, 24) == 0) s = string'(8'($urandom_range(0, 255)));
      else s = rand_piece();
      send_text(s, 1);
      if ($urandom_range(0, 79) == 0) send(8'($urandom), 1'b1, 1);
    end
    send(8'h00, 1'b1, 1);
    s_tvalid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d bytes, checked %0d tokens across words, numbers, operators, strings",
             bytes_sent, tokens_seen);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("mismatches: %0d, tokens outstanding: %0d", errors, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
